// ===== hdl/nmea_rmc_pkg.sv =====
package nmea_rmc_pkg;

    localparam int LINE_CAP        = 128;
    localparam int FRACTION_DIGITS = 5;
    localparam int LEN_W           = $clog2(LINE_CAP);
    localparam int CHECK_LIMIT     = 75;
    localparam logic [2:0] DONE_FIELD = 3'd7;
    localparam logic [30:0] E7_MAX = 31'd2000000000;

    // coordinate conversion constants
    localparam longint UNIT        = 64'd10 ** FRACTION_DIGITS;
    localparam longint DEG_DIV     = 100 * UNIT;
    localparam longint DEG_MAGIC   = (64'd1 << 32) / DEG_DIV;
    localparam int     Q_W         = $clog2(64'hFFFFFFFF / DEG_DIV + 1);
    localparam int     REM_W       = $clog2(2 * DEG_DIV);
    localparam int     MIN_W       = $clog2(DEG_DIV);
    localparam longint MIN_SCALE   = 64'd10 ** (7 - FRACTION_DIGITS);
    localparam int     X_W         = 30;
    localparam longint DIV60_MAGIC = (64'd1 << X_W) / 60;
    localparam int     F_W         = $clog2(((64'd1 << X_W) - 1) / 60 + 1);
    localparam longint SAT_Q       = 200;
    localparam int     CONV_STAGES = 6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;

    typedef enum logic [2:0] {
        PH_START,
        PH_SUM,
        PH_CHK1,
        PH_CHK2,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef struct packed {
        logic       line_ok;
        logic       fix;
        logic [7:0] ns;
        logic [7:0] ew;
    } meta_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_ZERO + {4'd0, n};
        else
            return CH_A + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [2:0] i);
        case (i)
            3'd1:    return CH_G;
            3'd2:    return CH_P;
            3'd3:    return CH_R;
            3'd4:    return CH_M;
            3'd5:    return CH_C;
            default: return CH_DOLLAR;
        endcase
    endfunction

    // acc*10+d, saturating at 32 bits
    function automatic logic [31:0] acc_push(input logic [31:0] acc, input logic [3:0] d);
        logic [35:0] v;
        v = 36'(acc) * 36'd10 + 36'(d);
        return (v[35:32] != 4'd0) ? 32'hFFFFFFFF : v[31:0];
    endfunction

    function automatic logic [19:0] pad_pow(input logic [2:0] frac);
        logic [2:0] k;
        k = 3'(FRACTION_DIGITS) - frac;
        case (k)
            3'd0:    return 20'd1;
            3'd1:    return 20'd10;
            3'd2:    return 20'd100;
            3'd3:    return 20'd1000;
            3'd4:    return 20'd10000;
            3'd5:    return 20'd100000;
            3'd6:    return 20'd1000000;
            default: return 20'd1;
        endcase
    endfunction

    // pad missing fraction digits with zeros, saturating
    function automatic logic [31:0] acc_scale(input logic [31:0] acc, input logic [2:0] frac);
        logic [51:0] p;
        p = 52'(acc) * 52'(pad_pow(frac));
        return (p[51:32] != 20'd0) ? 32'hFFFFFFFF : p[31:0];
    endfunction

endpackage

// ===== hdl/nmea_rmc_parser.sv =====
module nmea_rmc_parser
    import nmea_rmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    input  logic        adv,
    output logic        rec_valid,
    output meta_t       rec_meta,
    output logic [31:0] rec_lat,
    output logic [31:0] rec_lon
);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             dollar_reg, dollar_next;
    logic [7:0]       xor_reg, xor_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       chk0_reg, chk0_next, chk1_reg, chk1_next;
    logic [2:0]       prefix_reg, prefix_next;
    logic [2:0]       fnum_reg, fnum_next;
    logic [7:0]       status_reg, status_next;
    logic [31:0]      lat_reg, lat_next, lon_reg, lon_next;
    logic             numeric_reg, numeric_next;
    logic [1:0]       flen_reg, flen_next;
    logic             fdot_reg, fdot_next;
    logic             fdigit_reg, fdigit_next;
    logic [2:0]       ffrac_reg, ffrac_next;
    logic [31:0]      facc_reg, facc_next;
    logic [7:0]       pns_reg, pns_next, pew_reg, pew_next;

    logic             rec_valid_reg;
    meta_t            rec_meta_reg;
    logic [31:0]      rec_lat_reg, rec_lon_reg;

    logic             emit;
    logic             clear;
    logic             end_ok;
    logic             ok;
    logic [31:0]      padded;
    logic             is_digit;

    always_comb
    begin
        len_next     = len_reg;
        dollar_next  = dollar_reg;
        xor_next     = xor_reg;
        phase_next   = phase_reg;
        chk0_next    = chk0_reg;
        chk1_next    = chk1_reg;
        prefix_next  = prefix_reg;
        fnum_next    = fnum_reg;
        status_next  = status_reg;
        lat_next     = lat_reg;
        lon_next     = lon_reg;
        numeric_next = numeric_reg;
        flen_next    = flen_reg;
        fdot_next    = fdot_reg;
        fdigit_next  = fdigit_reg;
        ffrac_next   = ffrac_reg;
        facc_next    = facc_reg;
        pns_next     = pns_reg;
        pew_next     = pew_reg;
        emit         = 1'b0;
        clear        = 1'b0;
        end_ok       = 1'b1;
        ok           = 1'b0;
        is_digit     = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        padded       = acc_scale(facc_reg, ffrac_reg);

        if (accept)
        begin
            if (8'(len_reg) >= 8'(LINE_CAP - 1))
            begin
                // line full: drop the byte and restart
                clear = 1'b1;
            end
            else
            begin
                len_next = len_reg + 1'b1;
                case (phase_reg)
                    PH_START:
                    begin
                        dollar_next = (rx_byte == CH_DOLLAR);
                        if (rx_byte == CH_DOLLAR)
                        begin
                            phase_next   = PH_SUM;
                            numeric_next = 1'b1;
                            prefix_next  = 3'd1;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_SUM:
                    begin
                        if (8'(len_reg) >= 8'(CHECK_LIMIT) || rx_byte == CH_NUL)
                        begin
                            phase_next = PH_FAIL;
                        end
                        else
                        begin
                            if (numeric_reg && fnum_reg < DONE_FIELD)
                            begin
                                if (prefix_reg < 3'd6)
                                begin
                                    if (rx_byte == prefix_char(prefix_reg))
                                        prefix_next = prefix_reg + 1'b1;
                                    else
                                        numeric_next = 1'b0;
                                end
                                else if (rx_byte == CH_COMMA || rx_byte == CH_STAR)
                                begin
                                    case (fnum_reg)
                                        3'd1, 3'd3, 3'd5:
                                        begin
                                            end_ok = fdigit_reg;
                                            if (fdigit_reg && fnum_reg == 3'd3)
                                                lat_next = padded;
                                            if (fdigit_reg && fnum_reg == 3'd5)
                                                lon_next = padded;
                                        end
                                        3'd2, 3'd4: end_ok = (flen_reg == 2'd1);
                                        3'd6:       end_ok = (flen_reg != 2'd0);
                                        default:    end_ok = 1'b1;
                                    endcase
                                    if (!end_ok)
                                    begin
                                        numeric_next = 1'b0;
                                    end
                                    else
                                    begin
                                        fnum_next   = fnum_reg + 1'b1;
                                        flen_next   = 2'd0;
                                        fdot_next   = 1'b0;
                                        fdigit_next = 1'b0;
                                        ffrac_next  = 3'd0;
                                        facc_next   = 32'd0;
                                        if (rx_byte == CH_STAR && fnum_next != DONE_FIELD)
                                            numeric_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    if (flen_reg < 2'd2)
                                        flen_next = flen_reg + 1'b1;
                                    case (fnum_reg)
                                        3'd1, 3'd3, 3'd5:
                                        begin
                                            if (is_digit)
                                            begin
                                                fdigit_next = 1'b1;
                                                if (!fdot_reg)
                                                begin
                                                    facc_next = acc_push(facc_reg,
                                                        4'(rx_byte - CH_ZERO));
                                                end
                                                else if (ffrac_reg < 3'(FRACTION_DIGITS))
                                                begin
                                                    facc_next = acc_push(facc_reg,
                                                        4'(rx_byte - CH_ZERO));
                                                    ffrac_next = ffrac_reg + 1'b1;
                                                end
                                            end
                                            else if (rx_byte == CH_DOT && !fdot_reg)
                                            begin
                                                fdot_next = 1'b1;
                                            end
                                            else
                                            begin
                                                numeric_next = 1'b0;
                                            end
                                        end
                                        3'd2:
                                            if (flen_next == 2'd1) status_next = rx_byte;
                                        3'd4:
                                            if (flen_next == 2'd1) pns_next = rx_byte;
                                        3'd6:
                                            if (flen_next == 2'd1) pew_next = rx_byte;
                                        default:
                                            numeric_next = 1'b0;
                                    endcase
                                end
                            end
                            if (rx_byte == CH_STAR)
                                phase_next = PH_CHK1;
                            else
                                xor_next = xor_reg ^ rx_byte;
                        end
                    end
                    PH_CHK1:
                    begin
                        chk0_next  = rx_byte;
                        phase_next = PH_CHK2;
                    end
                    PH_CHK2:
                    begin
                        chk1_next  = rx_byte;
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                    end
                endcase

                if (rx_byte == CH_LF)
                begin
                    emit  = 1'b1;
                    clear = 1'b1;
                    ok    = dollar_next && phase_next == PH_DONE &&
                            chk0_next == hex_char(xor_next[7:4]) &&
                            chk1_next == hex_char(xor_next[3:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            dollar_reg  <= 1'b0;
            xor_reg     <= 8'd0;
            phase_reg   <= PH_START;
            chk0_reg    <= 8'd0;
            chk1_reg    <= 8'd0;
            prefix_reg  <= 3'd0;
            fnum_reg    <= 3'd0;
            status_reg  <= 8'd0;
            lat_reg     <= 32'd0;
            lon_reg     <= 32'd0;
            numeric_reg <= 1'b0;
            flen_reg    <= 2'd0;
            fdot_reg    <= 1'b0;
            fdigit_reg  <= 1'b0;
            ffrac_reg   <= 3'd0;
            facc_reg    <= 32'd0;
            pns_reg     <= 8'd0;
            pew_reg     <= 8'd0;
        end
        else if (clear)
        begin
            len_reg     <= '0;
            dollar_reg  <= 1'b0;
            xor_reg     <= 8'd0;
            phase_reg   <= PH_START;
            chk0_reg    <= 8'd0;
            chk1_reg    <= 8'd0;
            prefix_reg  <= 3'd0;
            fnum_reg    <= 3'd0;
            status_reg  <= 8'd0;
            lat_reg     <= 32'd0;
            lon_reg     <= 32'd0;
            numeric_reg <= 1'b0;
            flen_reg    <= 2'd0;
            fdot_reg    <= 1'b0;
            fdigit_reg  <= 1'b0;
            ffrac_reg   <= 3'd0;
            facc_reg    <= 32'd0;
            pns_reg     <= 8'd0;
            pew_reg     <= 8'd0;
        end
        else
        begin
            len_reg     <= len_next;
            dollar_reg  <= dollar_next;
            xor_reg     <= xor_next;
            phase_reg   <= phase_next;
            chk0_reg    <= chk0_next;
            chk1_reg    <= chk1_next;
            prefix_reg  <= prefix_next;
            fnum_reg    <= fnum_next;
            status_reg  <= status_next;
            lat_reg     <= lat_next;
            lon_reg     <= lon_next;
            numeric_reg <= numeric_next;
            flen_reg    <= flen_next;
            fdot_reg    <= fdot_next;
            fdigit_reg  <= fdigit_next;
            ffrac_reg   <= ffrac_next;
            facc_reg    <= facc_next;
            pns_reg     <= pns_next;
            pew_reg     <= pew_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_valid_reg <= 1'b0;
        else if (adv)
            rec_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            rec_meta_reg.line_ok <= ok;
            rec_meta_reg.fix     <= ok && numeric_next && fnum_next == DONE_FIELD &&
                                    status_next == CH_A;
            rec_meta_reg.ns      <= pns_next;
            rec_meta_reg.ew      <= pew_next;
            rec_lat_reg          <= lat_next;
            rec_lon_reg          <= lon_next;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec_meta  = rec_meta_reg;
    assign rec_lat   = rec_lat_reg;
    assign rec_lon   = rec_lon_reg;

endmodule

// ===== hdl/nmea_rmc_conv.sv =====
module nmea_rmc_conv
    import nmea_rmc_pkg::*;
(
    input  logic                   clk,
    input  logic [CONV_STAGES-1:0] load,
    input  logic [31:0]            digits,
    output logic [30:0]            e7
);

    logic [31:0]      v1_reg;
    logic [Q_W-1:0]   q1_reg, q2_reg, q3_reg;
    logic [REM_W-1:0] rem2_reg;
    logic [MIN_W-1:0] m3_reg;
    logic [X_W-1:0]   x4_reg, x5_reg;
    logic [30:0]      qe4_reg, qe5_reg, qe6_reg;
    logic             sat4_reg, sat5_reg, sat6_reg;
    logic [F_W-1:0]   f05_reg, f06_reg;
    logic [6:0]       r6_reg;

    logic [63:0]      prod1, prod5;
    logic [31:0]      rem;
    logic [X_W-1:0]   r60;
    logic [F_W-1:0]   f;
    logic [31:0]      sum;

    // degrees by reciprocal, quotient low by at most one
    assign prod1 = 64'(digits) * 64'(DEG_MAGIC);
    assign rem   = v1_reg - 32'(64'(q1_reg) * 64'(DEG_DIV));
    assign prod5 = 64'(x4_reg) * 64'(DIV60_MAGIC);
    assign r60   = x5_reg - X_W'(64'(f05_reg) * 64'd60);

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            v1_reg <= digits;
            q1_reg <= prod1[32 +: Q_W];
        end
        if (load[1])
        begin
            rem2_reg <= rem[REM_W-1:0];
            q2_reg   <= q1_reg;
        end
        if (load[2])
        begin
            if (rem2_reg >= REM_W'(DEG_DIV))
            begin
                q3_reg <= q2_reg + 1'b1;
                m3_reg <= MIN_W'(rem2_reg - REM_W'(DEG_DIV));
            end
            else
            begin
                q3_reg <= q2_reg;
                m3_reg <= rem2_reg[MIN_W-1:0];
            end
        end
        if (load[3])
        begin
            x4_reg   <= X_W'(64'(m3_reg) * 64'(MIN_SCALE));
            sat4_reg <= 64'(q3_reg) >= 64'(SAT_Q);
            qe4_reg  <= 31'(64'(q3_reg) * 64'd10000000);
        end
        if (load[4])
        begin
            f05_reg  <= prod5[X_W +: F_W];
            x5_reg   <= x4_reg;
            qe5_reg  <= qe4_reg;
            sat5_reg <= sat4_reg;
        end
        if (load[5])
        begin
            r6_reg   <= r60[6:0];
            f06_reg  <= f05_reg;
            qe6_reg  <= qe5_reg;
            sat6_reg <= sat5_reg;
        end
    end

    assign f   = f06_reg + F_W'(r6_reg >= 7'd60);
    assign sum = 32'(qe6_reg) + 32'(f);
    assign e7  = (sat6_reg || sum > 32'(E7_MAX)) ? E7_MAX : sum[30:0];

endmodule

// ===== hdl/nmea_rmc_line_checker_parser_top.sv =====
// throughput: one byte per cycle while rx_stall is low; the parser updates its line state on every accepted byte
// a 6-stage coordinate conversion pipeline sits between parser and result register
// bytes are only stalled when every pipeline stage and the result register are full
// reset (async, active low) clears the line state and the held position to zero
module nmea_rmc_line_checker_parser_top
    import nmea_rmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        line_ok,
    output logic        fix_updated,
    output logic [30:0] latitude_e7,
    output logic [30:0] longitude_e7,
    output logic [7:0]  north_south,
    output logic [7:0]  east_west
);

    logic                   rec_valid;
    meta_t                  rec_meta;
    logic [31:0]            rec_lat, rec_lon;
    logic [30:0]            lat_e7, lon_e7;

    logic                   v_reg [1:CONV_STAGES];
    meta_t                  meta_reg [1:CONV_STAGES];
    logic                   ready [0:CONV_STAGES+1];
    logic [CONV_STAGES-1:0] load;
    logic                   accept;

    logic                   out_valid_reg;
    logic                   ok_reg, fix_reg;
    logic [30:0]            lat_reg, lon_reg;
    logic [7:0]             ns_reg, ew_reg;

    // each stage can take a transaction when empty or when its contents move on
    always_comb
    begin
        ready[CONV_STAGES+1] = !out_valid_reg || !res_stall;
        for (int k = CONV_STAGES; k >= 1; k--)
            ready[k] = !v_reg[k] || ready[k+1];
        ready[0] = !rec_valid || ready[1];
        for (int k = 0; k < CONV_STAGES; k++)
            load[k] = ready[k+1];
    end

    assign accept   = rx_valid && ready[0];
    assign rx_stall = !ready[0];

    nmea_rmc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .adv       (ready[0]),
        .rec_valid (rec_valid),
        .rec_meta  (rec_meta),
        .rec_lat   (rec_lat),
        .rec_lon   (rec_lon)
    );

    nmea_rmc_conv u_conv_lat (
        .clk    (clk),
        .load   (load),
        .digits (rec_lat),
        .e7     (lat_e7)
    );

    nmea_rmc_conv u_conv_lon (
        .clk    (clk),
        .load   (load),
        .digits (rec_lon),
        .e7     (lon_e7)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= CONV_STAGES; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (ready[1])
                v_reg[1] <= rec_valid;
            for (int k = 2; k <= CONV_STAGES; k++)
                if (ready[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[1])
            meta_reg[1] <= rec_meta;
        for (int k = 2; k <= CONV_STAGES; k++)
            if (ready[k])
                meta_reg[k] <= meta_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            fix_reg       <= 1'b0;
            lat_reg       <= 31'd0;
            lon_reg       <= 31'd0;
            ns_reg        <= 8'd0;
            ew_reg        <= 8'd0;
        end
        else if (ready[CONV_STAGES+1])
        begin
            out_valid_reg <= v_reg[CONV_STAGES];
            if (v_reg[CONV_STAGES])
            begin
                ok_reg  <= meta_reg[CONV_STAGES].line_ok;
                fix_reg <= meta_reg[CONV_STAGES].fix;
                // held position moves only on a good fix
                if (meta_reg[CONV_STAGES].fix)
                begin
                    lat_reg <= lat_e7;
                    lon_reg <= lon_e7;
                    ns_reg  <= meta_reg[CONV_STAGES].ns;
                    ew_reg  <= meta_reg[CONV_STAGES].ew;
                end
            end
        end
    end

    assign res_valid    = out_valid_reg;
    assign line_ok      = ok_reg;
    assign fix_updated  = fix_reg;
    assign latitude_e7  = lat_reg;
    assign longitude_e7 = lon_reg;
    assign north_south  = ns_reg;
    assign east_west    = ew_reg;

`ifndef NO_ASSERTIONS
    a_fix_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!fix_reg || ok_reg))
        else $error("fix reported on a line that failed its check");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        lat_reg <= E7_MAX && lon_reg <= E7_MAX)
        else $error("held coordinate above saturation limit");

    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(ready[CONV_STAGES+1] && v_reg[CONV_STAGES] && meta_reg[CONV_STAGES].fix)
        |=> $stable(lat_reg) && $stable(lon_reg) && $stable(ns_reg))
        else $error("held position changed without a fix");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> (out_valid_reg && res_stall))
        else $error("input stalled while result register can move");
`endif

endmodule

// ===== verif/nmea_rmc_line_checker_parser_checker.sv =====
module nmea_rmc_line_checker_parser_checker
    import nmea_rmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_stall,
    input  logic [7:0]  rx_byte,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic        line_ok,
    input  logic        fix_updated,
    input  logic [30:0] latitude_e7,
    input  logic [30:0] longitude_e7,
    input  logic [7:0]  north_south,
    input  logic [7:0]  east_west,
    output int          errors,
    output int          pending,
    output int          lines_seen,
    output int          fixes_seen
);

    typedef struct packed {
        logic        ok;
        logic        fix;
        logic [30:0] lat;
        logic [30:0] lon;
        logic [7:0]  ns;
        logic [7:0]  ew;
    } line_result_t;

    line_result_t expected_lines[$];

    // line scanner state
    int unsigned len;
    bit          got_dollar;
    logic [7:0]  sum;
    phase_t      phase;
    logic [7:0]  chk0, chk1;
    int unsigned pfx;
    int unsigned fnum;
    logic [7:0]  status_byte;
    logic [31:0] lat_acc, lon_acc;
    bit          numeric;
    logic [30:0] hold_lat, hold_lon;
    logic [7:0]  hold_ns, hold_ew, next_ns, next_ew;
    int unsigned flen, ffrac;
    bit          fdot, fdigit;
    logic [31:0] facc;

    function automatic logic [31:0] push_digit(logic [31:0] a, int unsigned d);
        longint unsigned v;
        v = longint'(a) * 10 + d;
        return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
    endfunction

    function automatic logic [7:0] nibble_hex(logic [3:0] n);
        return (n < 10) ? 8'(48 + n) : 8'(55 + n);
    endfunction

    function automatic logic [30:0] degrees_e7(logic [31:0] v);
        longint unsigned u, d, m, r;
        u = 1;
        for (int i = 0; i < FRACTION_DIGITS; i++) u = u * 10;
        d = v / (100 * u);
        m = v - d * 100 * u;
        r = d * 10000000 + (m * 10000000) / (60 * u);
        return (r > 2000000000) ? E7_MAX : r[30:0];
    endfunction

    task automatic clear_field();
        flen = 0; fdot = 0; fdigit = 0; ffrac = 0; facc = 0;
    endtask

    task automatic restart_line();
        len = 0; got_dollar = 0; sum = 0; phase = PH_START; chk0 = 0; chk1 = 0;
        pfx = 0; fnum = 0; status_byte = 0; lat_acc = 0; lon_acc = 0; numeric = 0;
        next_ns = 0; next_ew = 0;
        clear_field();
    endtask

    function automatic bit close_field();
        case (fnum)
            1, 3, 5:
            begin
                if (!fdigit) return 0;
                for (int k = ffrac; k < FRACTION_DIGITS; k++) facc = push_digit(facc, 0);
                if (fnum == 3) lat_acc = facc;
                if (fnum == 5) lon_acc = facc;
                return 1;
            end
            2, 4: return flen == 1;
            6: return flen >= 1;
            default: return 1;
        endcase
    endfunction

    task automatic parse_rmc(logic [7:0] b);
        logic [7:0] want;
        want = (pfx == 1) ? CH_G : (pfx == 2) ? CH_P : (pfx == 3) ? CH_R :
               (pfx == 4) ? CH_M : (pfx == 5) ? CH_C : CH_DOLLAR;
        if (pfx < 6)
        begin
            if (b == want) pfx++;
            else numeric = 0;
        end
        else if (b == CH_COMMA || b == CH_STAR)
        begin
            if (!close_field())
                numeric = 0;
            else
            begin
                fnum++;
                clear_field();
                if (b == CH_STAR && fnum != DONE_FIELD) numeric = 0;
            end
        end
        else
        begin
            if (flen < 2) flen++;
            case (fnum)
                1, 3, 5:
                begin
                    if (b >= CH_ZERO && b <= CH_NINE)
                    begin
                        if (!fdot) facc = push_digit(facc, b - CH_ZERO);
                        else if (ffrac < FRACTION_DIGITS)
                        begin
                            facc = push_digit(facc, b - CH_ZERO);
                            ffrac++;
                        end
                        fdigit = 1;
                    end
                    else if (b == CH_DOT && !fdot) fdot = 1;
                    else numeric = 0;
                end
                2: if (flen == 1) status_byte = b;
                4: if (flen == 1) next_ns = b;
                6: if (flen == 1) next_ew = b;
                default: numeric = 0;
            endcase
        end
    endtask

    task automatic take_byte(logic [7:0] b);
        int unsigned p;
        bit ok, fix;
        line_result_t r;
        p = len;
        if (p >= LINE_CAP - 1)
        begin
            restart_line();
            return;
        end
        len = p + 1;
        case (phase)
            PH_START:
            begin
                got_dollar = (b == CH_DOLLAR);
                if (got_dollar)
                begin
                    phase = PH_SUM; numeric = 1; pfx = 1;
                end
                else phase = PH_FAIL;
            end
            PH_SUM:
            begin
                if (p >= CHECK_LIMIT || b == CH_NUL)
                    phase = PH_FAIL;
                else
                begin
                    if (numeric && fnum < DONE_FIELD) parse_rmc(b);
                    if (b == CH_STAR) phase = PH_CHK1;
                    else sum ^= b;
                end
            end
            PH_CHK1: begin chk0 = b; phase = PH_CHK2; end
            PH_CHK2: begin chk1 = b; phase = PH_DONE; end
            default: ;
        endcase
        if (b != CH_LF) return;
        ok = got_dollar && phase == PH_DONE && chk0 == nibble_hex(sum[7:4])
             && chk1 == nibble_hex(sum[3:0]);
        fix = ok && numeric && fnum == DONE_FIELD && status_byte == CH_A;
        if (fix)
        begin
            hold_lat = degrees_e7(lat_acc);
            hold_lon = degrees_e7(lon_acc);
            hold_ns = next_ns;
            hold_ew = next_ew;
        end
        r = '{ok, fix, hold_lat, hold_lon, hold_ns, hold_ew};
        expected_lines.push_back(r);
        restart_line();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_result_t e;
        if (!rst_n)
        begin
            restart_line();
            hold_lat = 0; hold_lon = 0; hold_ns = 0; hold_ew = 0;
            expected_lines.delete();
            errors <= 0;
            lines_seen <= 0;
            fixes_seen <= 0;
        end
        else
        begin
            if (rx_valid && !rx_stall) take_byte(rx_byte);
            if (res_valid && !res_stall)
            begin
                lines_seen <= lines_seen + 1;
                if (fix_updated) fixes_seen <= fixes_seen + 1;
                if (expected_lines.size() == 0)
                begin
                    if (errors < 10) $display("%0t: unexpected result transaction", $time);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_lines.pop_front();
                    if (e.ok !== line_ok || e.fix !== fix_updated || e.lat !== latitude_e7
                        || e.lon !== longitude_e7 || e.ns !== north_south
                        || e.ew !== east_west)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch exp ok=%0d fix=%0d lat=%0d lon=%0d ns=%h ew=%h act ok=%0d fix=%0d lat=%0d lon=%0d ns=%h ew=%h",
                                $time, e.ok, e.fix, e.lat, e.lon, e.ns, e.ew, line_ok,
                                fix_updated, latitude_e7, longitude_e7, north_south,
                                east_west);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending = expected_lines.size();
    end

endmodule

// ===== verif/tb_nmea_rmc_line_checker_parser_top.sv =====
module tb_nmea_rmc_line_checker_parser_top;
    import nmea_rmc_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        rx_valid = 0;
    logic        rx_stall;
    logic [7:0]  rx_byte = 0;
    logic        res_valid;
    logic        res_stall = 0;
    logic        line_ok, fix_updated;
    logic [30:0] latitude_e7, longitude_e7;
    logic [7:0]  north_south, east_west;
    int          errors, pending, lines_seen, fixes_seen;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          sent_bytes = 0;

    always #5 clk = ~clk;

    nmea_rmc_line_checker_parser_top dut (.*);

    nmea_rmc_line_checker_parser_checker checker_i (.*);

    always @(posedge clk)
        res_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_valid <= 0;
            @(posedge clk);
        end
        rx_valid <= 1;
        rx_byte <= b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_byte(s[i]);
    endtask

    function automatic string hex2(logic [7:0] v);
        return $sformatf("%02X", v);
    endfunction

    // wrap a body as $body*HH with correct or corrupted checksum
    function automatic string framed(string body, bit good);
        logic [7:0] x = 0;
        foreach (body[i]) x ^= body[i];
        if (!good) x ^= 8'(1 << $urandom_range(7));
        return {"$", body, "*", hex2(x), "\n"};
    endfunction

    function automatic string rand_num(int ip, int fp);
        string s = "";
        for (int i = 0; i < ip; i++) s = {s, string'(8'(48 + $urandom_range(9)))};
        if (fp >= 0)
        begin
            s = {s, "."};
            for (int i = 0; i < fp; i++) s = {s, string'(8'(48 + $urandom_range(9)))};
        end
        return s;
    endfunction

    function automatic string rand_rmc();
        string t, la, lo, st, ns, ew, s;
        t  = rand_num($urandom_range(1, 6), $urandom_range(0, 3) == 0 ? -1 : 2);
        la = rand_num($urandom_range(1, 4), $urandom_range(0, 7) - 1);
        lo = rand_num($urandom_range(1, 5), $urandom_range(0, 7) - 1);
        st = ($urandom_range(4) == 0) ? "V" : "A";
        ns = $urandom_range(1) ? "N" : "S";
        ew = $urandom_range(1) ? "E" : "W";
        if ($urandom_range(9) == 0) la = {la, "9999999999"};
        s = {"GPRMC,", t, ",", st, ",", la, ",", ns, ",", lo, ",", ew};
        if ($urandom_range(1)) s = {s, ",0.5,54.7,191194,020.3,E"};
        case ($urandom_range(15))
            0: s = {"GPRMX", s.substr(5, s.len() - 1)};
            1: s = {s.substr(0, 6), "x", s.substr(7, s.len() - 1)};
            2: s = {s.substr(0, 5), ",,", s.substr(7, s.len() - 1)};
            default: ;
        endcase
        return s;
    endfunction

    task automatic random_line();
        string s;
        int k;
        k = $urandom_range(99);
        if (k < 70)
            send_text(framed(rand_rmc(), $urandom_range(9) != 0));
        else if (k < 85)
        begin
            s = "";
            repeat ($urandom_range(40)) s = {s, string'(8'($urandom_range(1, 255)))};
            send_text({s, "\n"});
        end
        else
        begin
            repeat ($urandom_range(1, 30)) send_byte($urandom_range(255));
            send_text("\n");
        end
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        string s;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: good fix, status V, empty fields, bad check, overlong, nul, cap
        send_text(framed("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394", 1));
        send_text(framed("GPRMC,123519,V,4807.038,N,01131.000,E", 1));
        send_text(framed("GPRMC,12a519,A,4807.038,N,01131.000,E", 1));
        send_text(framed("GPRMC,0,A,9999.99999999,S,99999.9,W", 1));
        send_text(framed("GPRMC,1,A,9999999999999,S,0,W", 1));
        send_text(framed("GPRMC,1,A,0000.00000,N,0,E", 1));
        send_text(framed("GPRMC,1,A,.,N,1,E", 1));
        send_text(framed("GPRMC,1,A,1.2.3,N,1,E", 1));
        send_text(framed("GPRMC,1,AA,1,N,1,E", 1));
        send_text(framed("GPRMC,1,A,1,NS,1,E", 1));
        send_text(framed("GPRMC,1,A,1,N,1,", 1));
        send_text(framed("GPRMC,1,A,1,N,1,Eww", 1));
        send_text(framed("GPRMC,1,A,1,N,1", 1));
        send_text(framed("GPGGA,1,2,3", 0));
        send_text(framed("GPGGA,1,2,3", 1));
        send_text("GPRMC*00\n");
        send_text("\n");
        send_text("$*0\n");
        send_text("$A*4");
        send_text("\n");
        s = "";
        repeat (80) s = {s, "Z"};
        send_text(framed(s, 1));
        send_text({"$ab", string'(8'h00), "cd*00\n"});
        s = "";
        repeat (140) s = {s, "Z"};
        send_text({"$", s.substr(0, 130), "\n"});
        send_text(framed("GPRMC,1,A,5959.99999,N,17959.99999,W", 1));
        send_text({"$", string'(8'hFF), string'(8'h80), "*7F\n"});
        rx_valid <= 0;
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 59 : 10) : 0;
            recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 10 : 0;
            repeat (5) random_line();
        end
        rx_valid <= 0;
        drain();
        $display("covered %0d bytes, %0d result transactions, %0d coordinate updates",
            sent_bytes, lines_seen, fixes_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/nmea_rmc_pkg.sv
hdl/nmea_rmc_parser.sv
hdl/nmea_rmc_conv.sv
hdl/nmea_rmc_line_checker_parser_top.sv
verif/nmea_rmc_line_checker_parser_checker.sv
verif/tb_nmea_rmc_line_checker_parser_top.sv
